@@ rtl/ccrb_pkg.sv @@
// Package for the cache control register block: request/response types, register map and decode.
`timescale 1ns / 1ps

package ccrb_pkg;

  // Default placement of the register window and size of the attribute table.
  localparam logic [31:0] BASE_ADDRESS_DEF = 32'd25427968;
  localparam int unsigned MAR_COUNT_DEF    = 256;

  // The window spans 64 KiB, so an offset has 16 bits.
  localparam int unsigned OFF_W     = 16;
  localparam int unsigned MAR_IDX_W = 8;

  // Register offsets within the window.
  localparam logic [OFF_W-1:0] OFF_L2_CFG    = 16'h0000;
  localparam logic [OFF_W-1:0] OFF_L1P_CFG   = 16'h0020;
  localparam logic [OFF_W-1:0] OFF_L1P_FRZ   = 16'h0024;
  localparam logic [OFF_W-1:0] OFF_L1D_CFG   = 16'h0040;
  localparam logic [OFF_W-1:0] OFF_L1D_FRZ   = 16'h0044;
  localparam logic [OFF_W-1:0] OFF_BASE0     = 16'h4000;
  localparam logic [OFF_W-1:0] OFF_BASE1     = 16'h4010;
  localparam logic [OFF_W-1:0] OFF_BASE2     = 16'h4018;
  localparam logic [OFF_W-1:0] OFF_BASE3     = 16'h4020;
  localparam logic [OFF_W-1:0] OFF_BASE4     = 16'h4030;
  localparam logic [OFF_W-1:0] OFF_BASE5     = 16'h4040;
  localparam logic [OFF_W-1:0] OFF_BASE6     = 16'h4048;
  localparam logic [OFF_W-1:0] OFF_WC0       = 16'h4004;
  localparam logic [OFF_W-1:0] OFF_WC1       = 16'h4014;
  localparam logic [OFF_W-1:0] OFF_WC2       = 16'h401c;
  localparam logic [OFF_W-1:0] OFF_WC3       = 16'h4024;
  localparam logic [OFF_W-1:0] OFF_WC4       = 16'h4034;
  localparam logic [OFF_W-1:0] OFF_WC5       = 16'h4044;
  localparam logic [OFF_W-1:0] OFF_WC6       = 16'h404c;
  localparam logic [OFF_W-1:0] OFF_GOP0      = 16'h5000;
  localparam logic [OFF_W-1:0] OFF_GOP1      = 16'h5004;
  localparam logic [OFF_W-1:0] OFF_GOP2      = 16'h5008;
  localparam logic [OFF_W-1:0] OFF_GOP3      = 16'h5028;
  localparam logic [OFF_W-1:0] OFF_GOP4      = 16'h5040;
  localparam logic [OFF_W-1:0] OFF_GOP5      = 16'h5044;
  localparam logic [OFF_W-1:0] OFF_GOP6      = 16'h5048;
  localparam logic [OFF_W-1:0] OFF_MAR_FIRST = 16'h8000;
  localparam logic [OFF_W-1:0] OFF_MAR_LAST  = 16'h83fc;

  // Implemented attribute entries.
  localparam logic [MAR_IDX_W-1:0] MAR_LO_FIRST  = 8'd64;
  localparam logic [MAR_IDX_W-1:0] MAR_LO_LAST   = 8'd103;
  localparam logic [MAR_IDX_W-1:0] MAR_MID       = 8'd128;
  localparam logic [MAR_IDX_W-1:0] MAR_HI_FIRST  = 8'd192;
  localparam logic [MAR_IDX_W-1:0] MAR_HI_LAST   = 8'd223;

  localparam int unsigned BASE_SLOTS = 7;
  localparam logic [3:0]  WRITE_SIZE = 4'd4;

  localparam logic [2:0] CFG_L1_RESET = 3'd7;

  typedef enum logic [3:0] {
    SEL_NONE,
    SEL_L2_CFG,
    SEL_L1P_CFG,
    SEL_L1P_FRZ,
    SEL_L1D_CFG,
    SEL_L1D_FRZ,
    SEL_BASE,
    SEL_ZERO,
    SEL_MAR
  } reg_sel_t;

  typedef enum logic {
    OP_READ  = 1'b0,
    OP_WRITE = 1'b1
  } op_t;

  typedef struct packed {
    logic        operation;
    logic [31:0] address;
    logic [63:0] write_data;
    logic [3:0]  access_size;
    logic        commit;
  } req_t;

  typedef struct packed {
    logic        ok;
    logic [31:0] read_data;
  } rsp_t;

  function automatic reg_sel_t decode_sel(input logic [OFF_W-1:0] off);
    reg_sel_t sel;
    sel = SEL_NONE;
    unique case (off)
      OFF_L2_CFG:  sel = SEL_L2_CFG;
      OFF_L1P_CFG: sel = SEL_L1P_CFG;
      OFF_L1P_FRZ: sel = SEL_L1P_FRZ;
      OFF_L1D_CFG: sel = SEL_L1D_CFG;
      OFF_L1D_FRZ: sel = SEL_L1D_FRZ;
      OFF_BASE0, OFF_BASE1, OFF_BASE2, OFF_BASE3,
      OFF_BASE4, OFF_BASE5, OFF_BASE6: sel = SEL_BASE;
      OFF_WC0, OFF_WC1, OFF_WC2, OFF_WC3, OFF_WC4, OFF_WC5, OFF_WC6,
      OFF_GOP0, OFF_GOP1, OFF_GOP2, OFF_GOP3, OFF_GOP4, OFF_GOP5,
      OFF_GOP6: sel = SEL_ZERO;
      default: begin
        if (off >= OFF_MAR_FIRST && off <= OFF_MAR_LAST) sel = SEL_MAR;
        else sel = SEL_NONE;
      end
    endcase
    return sel;
  endfunction

  function automatic logic [2:0] base_slot(input logic [OFF_W-1:0] off);
    logic [2:0] slot;
    slot = 3'd0;
    unique case (off)
      OFF_BASE0: slot = 3'd0;
      OFF_BASE1: slot = 3'd1;
      OFF_BASE2: slot = 3'd2;
      OFF_BASE3: slot = 3'd3;
      OFF_BASE4: slot = 3'd4;
      OFF_BASE5: slot = 3'd5;
      OFF_BASE6: slot = 3'd6;
      default:   slot = 3'd0;
    endcase
    return slot;
  endfunction

  function automatic logic mar_idx_impl(input logic [MAR_IDX_W-1:0] idx);
    return (idx >= MAR_LO_FIRST && idx <= MAR_LO_LAST) || idx == MAR_MID ||
           (idx >= MAR_HI_FIRST && idx <= MAR_HI_LAST);
  endfunction

endpackage

@@ rtl/cache_control_register_block_top.sv @@
// Top level of the cache control register block: a bus slave with config, freeze and MAR registers.
// A request is registered into the decode stage and its response then into the output register.
// No new request is taken while one is in the decode stage, for the read-then-write pass over
// the synchronous MAR memory. Reset clears the control, config, freeze and base registers to
// their defaults; MAR entries read as zero through per-entry valid bits until first written.
`timescale 1ns / 1ps

module cache_control_register_block_top #(
  parameter logic [31:0] BASE_ADDRESS = ccrb_pkg::BASE_ADDRESS_DEF,
  parameter int unsigned MAR_COUNT    = ccrb_pkg::MAR_COUNT_DEF
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_stall,
  input  ccrb_pkg::req_t  in_req,
  output logic            out_valid,
  input  logic            out_stall,
  output ccrb_pkg::rsp_t  out_rsp
);

  localparam int unsigned OFF_W = ccrb_pkg::OFF_W;
  localparam int unsigned IDX_W = ccrb_pkg::MAR_IDX_W;

  // ---------------------------------------------------------------------------
  // Request stage. The window check is one 33-bit subtract so that a window
  // near the top of the address space cannot wrap. The MAR memory read is
  // launched here, so its data is ready for the decode stage.
  // ---------------------------------------------------------------------------
  logic              in_accept;
  logic [32:0]       off_full;
  logic              in_window;
  logic              pre_ok;
  logic [IDX_W-1:0]  in_idx;
  logic              in_idx_mapped;

  assign in_accept = in_valid && !in_stall;
  assign off_full  = {1'b0, in_req.address} - {1'b0, BASE_ADDRESS};
  assign in_window = !off_full[32] && (off_full[31:OFF_W] == '0);
  assign in_idx    = off_full[IDX_W+1:2];
  assign in_idx_mapped = {{(32-IDX_W){1'b0}}, in_idx} < 32'(MAR_COUNT);

  // A write must be one full word whose data fits in 32 bits.
  assign pre_ok = in_window && (in_req.address[1:0] == 2'b00) &&
                  (in_req.operation == ccrb_pkg::OP_READ ||
                   (in_req.access_size == ccrb_pkg::WRITE_SIZE &&
                    in_req.write_data[63:32] == '0));

  logic              busy_r;
  logic              op_r;
  logic [OFF_W-1:0]  off_r;
  logic [31:0]       word_r;
  logic              commit_r;
  logic              pre_ok_r;
  logic              mar_q_r;

  // MAR storage: one-bit entries in a synchronous memory plus valid bits,
  // so that an entry never written reads as its reset value of zero.
  logic              mar_mem [MAR_COUNT];
  logic [MAR_COUNT-1:0] mar_vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else begin
      busy_r <= in_accept;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      op_r     <= in_req.operation;
      off_r    <= off_full[OFF_W-1:0];
      word_r   <= in_req.write_data[31:0];
      commit_r <= in_req.commit;
      pre_ok_r <= pre_ok;
    end
  end

  // ---------------------------------------------------------------------------
  // Decode and update stage. Only one request is in flight, so the memory
  // write of one request always lands before the next request's read: the
  // input stalls while busy_r is high, which is the interlock.
  // ---------------------------------------------------------------------------
  ccrb_pkg::reg_sel_t sel;
  logic [IDX_W-1:0]   idx;
  logic               idx_mapped;
  logic               mar_ok;
  logic               rsp_ok;
  logic [31:0]        rsp_data;
  logic               do_write;
  logic               mar_bit;

  assign sel        = ccrb_pkg::decode_sel(off_r);
  assign idx        = off_r[IDX_W+1:2];
  assign idx_mapped = {{(32-IDX_W){1'b0}}, idx} < 32'(MAR_COUNT);
  assign mar_ok     = idx_mapped && ccrb_pkg::mar_idx_impl(idx);
  assign mar_bit    = idx_mapped ? (mar_vld_r[idx] & mar_q_r) : 1'b0;

  // Block-base registers are write-only; a read of one is refused.
  assign rsp_ok = pre_ok_r && (sel != ccrb_pkg::SEL_NONE) &&
                  (sel != ccrb_pkg::SEL_BASE || op_r == ccrb_pkg::OP_WRITE) &&
                  (sel != ccrb_pkg::SEL_MAR || mar_ok);

  assign do_write = busy_r && rsp_ok && op_r == ccrb_pkg::OP_WRITE && commit_r;

  always_ff @(posedge clk) begin
    if (in_accept && in_idx_mapped) begin
      mar_q_r <= mar_mem[in_idx];
    end
    if (do_write && sel == ccrb_pkg::SEL_MAR) begin
      mar_mem[idx] <= word_r[0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mar_vld_r <= '0;
    end else if (do_write && sel == ccrb_pkg::SEL_MAR) begin
      mar_vld_r[idx] <= 1'b1;
    end
  end

  // Configuration and freeze registers.
  logic [3:0]  l2_cfg_r,  l2_cfg_nxt;
  logic [2:0]  l1p_cfg_r, l1p_cfg_nxt;
  logic [16:0] l1p_frz_r, l1p_frz_nxt;
  logic [2:0]  l1d_cfg_r, l1d_cfg_nxt;
  logic [16:0] l1d_frz_r, l1d_frz_nxt;
  logic [31:0] block_base_r [ccrb_pkg::BASE_SLOTS];

  always_comb begin
    l2_cfg_nxt  = l2_cfg_r;
    l1p_cfg_nxt = l1p_cfg_r;
    l1p_frz_nxt = l1p_frz_r;
    l1d_cfg_nxt = l1d_cfg_r;
    l1d_frz_nxt = l1d_frz_r;
    if (do_write) begin
      unique case (sel)
        ccrb_pkg::SEL_L2_CFG:  l2_cfg_nxt  = word_r[3:0];
        ccrb_pkg::SEL_L1P_CFG: l1p_cfg_nxt = word_r[2:0];
        // A freeze write moves the old enable bit up to bit 16.
        ccrb_pkg::SEL_L1P_FRZ: l1p_frz_nxt = {l1p_frz_r[0], 15'd0, word_r[0]};
        ccrb_pkg::SEL_L1D_CFG: l1d_cfg_nxt = word_r[2:0];
        ccrb_pkg::SEL_L1D_FRZ: l1d_frz_nxt = {l1d_frz_r[0], 15'd0, word_r[0]};
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      l2_cfg_r  <= '0;
      l1p_cfg_r <= ccrb_pkg::CFG_L1_RESET;
      l1p_frz_r <= '0;
      l1d_cfg_r <= ccrb_pkg::CFG_L1_RESET;
      l1d_frz_r <= '0;
      for (int i = 0; i < ccrb_pkg::BASE_SLOTS; i++) begin
        block_base_r[i] <= '0;
      end
    end else begin
      l2_cfg_r  <= l2_cfg_nxt;
      l1p_cfg_r <= l1p_cfg_nxt;
      l1p_frz_r <= l1p_frz_nxt;
      l1d_cfg_r <= l1d_cfg_nxt;
      l1d_frz_r <= l1d_frz_nxt;
      if (do_write && sel == ccrb_pkg::SEL_BASE) begin
        block_base_r[ccrb_pkg::base_slot(off_r)] <= word_r;
      end
    end
  end

  // Read data is returned only for accepted reads; writes answer with zero.
  always_comb begin
    rsp_data = '0;
    if (rsp_ok && op_r == ccrb_pkg::OP_READ) begin
      unique case (sel)
        ccrb_pkg::SEL_L2_CFG:  rsp_data = {28'd0, l2_cfg_r};
        ccrb_pkg::SEL_L1P_CFG: rsp_data = {29'd0, l1p_cfg_r};
        ccrb_pkg::SEL_L1P_FRZ: rsp_data = {15'd0, l1p_frz_r};
        ccrb_pkg::SEL_L1D_CFG: rsp_data = {29'd0, l1d_cfg_r};
        ccrb_pkg::SEL_L1D_FRZ: rsp_data = {15'd0, l1d_frz_r};
        ccrb_pkg::SEL_MAR:     rsp_data = {31'd0, mar_bit};
        default:               rsp_data = '0;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Output register. A new request is taken only when this register is empty
  // or is being emptied, so it is always free when the decode stage finishes.
  // ---------------------------------------------------------------------------
  logic           out_valid_r;
  ccrb_pkg::rsp_t out_rsp_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (busy_r) begin
      out_valid_r <= 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (busy_r) begin
      out_rsp_r.ok        <= rsp_ok;
      out_rsp_r.read_data <= rsp_data;
    end
  end

  assign in_stall  = busy_r || (out_valid_r && out_stall);
  assign out_valid = out_valid_r;
  assign out_rsp   = out_rsp_r;

  // ---------------------------------------------------------------------------
  // Assertions.
  // ---------------------------------------------------------------------------
  a_accept_busy : assert property (@(posedge clk) disable iff (!rst_n)
    in_accept |=> busy_r)
    else $error("accepted request did not enter the decode stage");

  a_busy_one_cycle : assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |=> (!busy_r && out_valid_r))
    else $error("decode stage did not finish into the output register");

  a_no_overwrite : assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> (!out_valid_r || !$past(out_stall)))
    else $error("response would overwrite a waiting response");

  a_rejected_zero : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_rsp_r.ok) |-> (out_rsp_r.read_data == '0))
    else $error("rejected request returned nonzero read data");

endmodule

@@ verif/tb_cache_control_register_block_top.sv @@
// Self-checking testbench for the cache control register block top level.
`timescale 1ns / 1ps

module tb_cache_control_register_block_top;
  import ccrb_pkg::*;

  localparam logic [31:0] WIN_BASE    = BASE_ADDRESS_DEF;
  localparam int          CYCLE_LIMIT = 200000;
  localparam int          HOLD_CYCLES = 200;

  // The scoreboard keeps its own copy of every register of the block. Each
  // accepted request is decoded against that copy, the response it should
  // produce is queued, and the copy is updated for committed writes. Responses
  // from the block are then matched in order against the queue.
  class access_scoreboard;
    rsp_t        expected_q[$];
    int          error_count;
    logic [3:0]  l2_cfg;
    logic [2:0]  l1p_cfg;
    logic [2:0]  l1d_cfg;
    logic [16:0] l1p_frz;
    logic [16:0] l1d_frz;
    logic [31:0] base_regs [BASE_SLOTS];
    logic        mar_table [256];

    function new();
      error_count = 0;
      l2_cfg  = '0;
      l1p_cfg = CFG_L1_RESET;
      l1d_cfg = CFG_L1_RESET;
      l1p_frz = '0;
      l1d_frz = '0;
      foreach (base_regs[i]) base_regs[i] = '0;
      foreach (mar_table[i]) mar_table[i] = 1'b0;
    endfunction

    function void note_access(req_t r);
      reg_sel_t    sel;
      logic [32:0] addr_ext;
      logic [32:0] win_lo;
      logic [31:0] delta;
      logic [15:0] off;
      logic [7:0]  idx;
      logic [31:0] word;
      logic [31:0] value;
      logic [2:0]  slot;
      bit          write_ok;
      rsp_t        exp;
      addr_ext = {1'b0, r.address};
      win_lo   = {1'b0, WIN_BASE};
      delta    = r.address - WIN_BASE;
      off      = delta[15:0];
      idx      = off[9:2];
      word     = r.write_data[31:0];
      sel      = SEL_NONE;
      slot     = 3'd0;
      value    = '0;
      exp      = '0;

      // The upper window bound is taken in 33 bits so that it cannot wrap.
      if (addr_ext >= win_lo && addr_ext < win_lo + 33'h1_0000 &&
          r.address[1:0] == 2'b00) begin
        case (off)
          OFF_L2_CFG:  sel = SEL_L2_CFG;
          OFF_L1P_CFG: sel = SEL_L1P_CFG;
          OFF_L1P_FRZ: sel = SEL_L1P_FRZ;
          OFF_L1D_CFG: sel = SEL_L1D_CFG;
          OFF_L1D_FRZ: sel = SEL_L1D_FRZ;
          OFF_BASE0: begin sel = SEL_BASE; slot = 3'd0; end
          OFF_BASE1: begin sel = SEL_BASE; slot = 3'd1; end
          OFF_BASE2: begin sel = SEL_BASE; slot = 3'd2; end
          OFF_BASE3: begin sel = SEL_BASE; slot = 3'd3; end
          OFF_BASE4: begin sel = SEL_BASE; slot = 3'd4; end
          OFF_BASE5: begin sel = SEL_BASE; slot = 3'd5; end
          OFF_BASE6: begin sel = SEL_BASE; slot = 3'd6; end
          OFF_WC0, OFF_WC1, OFF_WC2, OFF_WC3, OFF_WC4, OFF_WC5, OFF_WC6,
          OFF_GOP0, OFF_GOP1, OFF_GOP2, OFF_GOP3, OFF_GOP4, OFF_GOP5,
          OFF_GOP6: sel = SEL_ZERO;
          default: begin
            if (off >= OFF_MAR_FIRST && off <= OFF_MAR_LAST && idx < MAR_COUNT_DEF &&
                ((idx >= MAR_LO_FIRST && idx <= MAR_LO_LAST) || idx == MAR_MID ||
                 (idx >= MAR_HI_FIRST && idx <= MAR_HI_LAST)))
              sel = SEL_MAR;
          end
        endcase
      end

      if (r.operation == OP_READ) begin
        case (sel)
          SEL_L2_CFG:  value = {28'd0, l2_cfg};
          SEL_L1P_CFG: value = {29'd0, l1p_cfg};
          SEL_L1P_FRZ: value = {15'd0, l1p_frz};
          SEL_L1D_CFG: value = {29'd0, l1d_cfg};
          SEL_L1D_FRZ: value = {15'd0, l1d_frz};
          SEL_MAR:     value = {31'd0, mar_table[idx]};
          default:     value = '0;
        endcase
        // Block-base registers are write-only, so a read of one is refused.
        exp.ok        = (sel != SEL_NONE && sel != SEL_BASE);
        exp.read_data = exp.ok ? value : '0;
      end else begin
        write_ok = (r.access_size == WRITE_SIZE) && (r.write_data[63:32] == 32'd0);
        exp.ok   = write_ok && (sel != SEL_NONE);
        if (exp.ok && r.commit) begin
          case (sel)
            SEL_L2_CFG:  l2_cfg  = word[3:0];
            SEL_L1P_CFG: l1p_cfg = word[2:0];
            SEL_L1P_FRZ: l1p_frz = {l1p_frz[0], 15'd0, word[0]};
            SEL_L1D_CFG: l1d_cfg = word[2:0];
            SEL_L1D_FRZ: l1d_frz = {l1d_frz[0], 15'd0, word[0]};
            SEL_BASE:    base_regs[slot] = word;
            SEL_MAR:     mar_table[idx] = word[0];
            default: ;
          endcase
        end
      end
      expected_q.push_back(exp);
    endfunction

    function void check_response(rsp_t got);
      rsp_t exp;
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected response ok=%0b read_data=%08h",
                 $time, got.ok, got.read_data);
        error_count++;
        return;
      end
      exp = expected_q.pop_front();
      if (got.ok !== exp.ok || got.read_data !== exp.read_data) begin
        $display("%0t: response mismatch: expected ok=%0b read_data=%08h, %s%0b read_data=%08h",
                 $time, exp.ok, exp.read_data, "actual ok=", got.ok, got.read_data);
        error_count++;
      end
    endfunction

    function int outstanding();
      return expected_q.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  req_t in_req;
  logic out_valid;
  logic out_stall;
  rsp_t out_rsp;

  // Flags shared between the stimulus and the response side. tx_quiet and
  // rx_quiet switch off the random gaps; hold_long asks the response side for
  // one long stall so that the block backs up into its request port.
  bit tx_quiet  = 1'b0;
  bit rx_quiet  = 1'b0;
  bit hold_long = 1'b0;

  logic [15:0] reg_offsets [26];

  access_scoreboard sb = new();

  always #6 clk = ~clk;

  cache_control_register_block_top u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_req    (in_req),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_rsp   (out_rsp)
  );

  // Both handshakes are sampled right after the rising edge. All testbench
  // drives are nonblocking, so the values seen here are the ones that were
  // present at the edge, whatever the order of processes in the time step.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) sb.note_access(in_req);
      if (out_valid && !out_stall) sb.check_response(out_rsp);
    end
  end

  function automatic req_t make_req(input op_t op, input logic [31:0] addr,
                                    input logic [63:0] data, input logic [3:0] size,
                                    input logic commit);
    req_t r;
    r.operation   = op;
    r.address     = addr;
    r.write_data  = data;
    r.access_size = size;
    r.commit      = commit;
    return r;
  endfunction

  function automatic logic [31:0] reg_addr(input logic [15:0] off);
    return WIN_BASE + {16'd0, off};
  endfunction

  function automatic logic [31:0] mar_addr(input logic [7:0] idx);
    return reg_addr(OFF_MAR_FIRST + {6'd0, idx, 2'b00});
  endfunction

  // Most random requests are well formed: an aligned register or attribute
  // table address, size 4 and 32-bit data, so they reach the register state.
  // The remaining ones are noise that should mostly be refused.
  function automatic req_t random_access();
    req_t        r;
    int          pick;
    logic [15:0] off;
    pick          = $urandom_range(0, 99);
    r.operation   = 1'($urandom_range(0, 1));
    r.commit      = ($urandom_range(0, 4) != 0);
    r.access_size = WRITE_SIZE;
    r.write_data  = {32'd0, $urandom};
    off           = 16'($urandom_range(0, 65535));
    if (pick < 45) begin
      r.address = reg_addr(reg_offsets[5'($urandom_range(0, 25))]);
    end else if (pick < 85) begin
      r.address = mar_addr(8'($urandom_range(0, 255)));
    end else begin
      r.write_data  = {$urandom, $urandom};
      r.access_size = 4'($urandom_range(0, 8));
      r.commit      = 1'($urandom_range(0, 1));
      if (pick < 89) r.address = $urandom;
      else if (pick < 92) r.address = WIN_BASE - $urandom_range(1, 64);
      else if (pick < 96) r.address = reg_addr(off);
      else r.address = reg_addr(reg_offsets[5'($urandom_range(0, 25))]);
    end
    return r;
  endfunction

  // Offers one request after a random gap and returns once it is accepted.
  // Valid stays high into the next request when no gap is drawn.
  task automatic send_access(input req_t r);
    int gap;
    gap = tx_quiet ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_req   <= r;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
  endtask

  // Stops offering requests and waits until every expected response is in.
  // The first edge is always waited for, so the request accepted at the
  // current edge has been noted before the count is looked at.
  task automatic drain_requests();
    in_valid <= 1'b0;
    do @(posedge clk); while (sb.outstanding() != 0);
  endtask

  // Response side: before each response it stalls for a random number of
  // cycles, and once, when asked, for a long stretch counted right here.
  initial begin : response_side
    int stall_cycles;
    out_stall <= 1'b0;
    forever begin
      if (hold_long) begin
        stall_cycles = HOLD_CYCLES;
        hold_long    = 1'b0;
      end else begin
        stall_cycles = rx_quiet ? 0 : $urandom_range(0, 5);
      end
      if (stall_cycles > 0) begin
        out_stall <= 1'b1;
        repeat (stall_cycles) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
    end
  end

  initial begin : watchdog
    int cycle_count;
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Simulation FAILED");
    $finish;
  end

  initial begin : stimulus
    rst_n    <= 1'b0;
    in_valid <= 1'b0;
    in_req   <= '0;
    reg_offsets = '{OFF_L2_CFG, OFF_L1P_CFG, OFF_L1P_FRZ, OFF_L1D_CFG, OFF_L1D_FRZ,
                    OFF_BASE0, OFF_BASE1, OFF_BASE2, OFF_BASE3, OFF_BASE4, OFF_BASE5,
                    OFF_BASE6, OFF_WC0, OFF_WC1, OFF_WC2, OFF_WC3, OFF_WC4, OFF_WC5,
                    OFF_WC6, OFF_GOP0, OFF_GOP1, OFF_GOP2, OFF_GOP3, OFF_GOP4, OFF_GOP5,
                    OFF_GOP6};
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset value, then an all-ones write of which only the low nibble sticks.
    // The read carries junk data and size, which a read must ignore.
    send_access(make_req(OP_READ, reg_addr(OFF_L2_CFG), '0, 4'd0, 1'b0));
    send_access(make_req(OP_WRITE, reg_addr(OFF_L2_CFG), 64'hffff_ffff, WRITE_SIZE, 1'b1));
    send_access(make_req(OP_READ, reg_addr(OFF_L2_CFG), '1, 4'd8, 1'b1));

    // The second freeze write moves the old bit 0 up into bit 16.
    send_access(make_req(OP_WRITE, reg_addr(OFF_L1P_FRZ), 64'hffff_ffff, WRITE_SIZE, 1'b1));
    send_access(make_req(OP_WRITE, reg_addr(OFF_L1P_FRZ), 64'h0, WRITE_SIZE, 1'b1));
    send_access(make_req(OP_READ, reg_addr(OFF_L1P_FRZ), '0, 4'd0, 1'b0));

    // A check-only write is acknowledged but leaves the register at reset.
    send_access(make_req(OP_WRITE, reg_addr(OFF_L1D_CFG), 64'h2, WRITE_SIZE, 1'b0));
    send_access(make_req(OP_READ, reg_addr(OFF_L1D_CFG), '0, 4'd0, 1'b0));

    // Write-only base register, plus the registers that read as zero.
    send_access(make_req(OP_WRITE, reg_addr(OFF_BASE6), 64'hdead_beef, WRITE_SIZE, 1'b1));
    send_access(make_req(OP_READ, reg_addr(OFF_BASE6), '0, 4'd0, 1'b0));
    send_access(make_req(OP_READ, reg_addr(OFF_WC0), '0, 4'd0, 1'b0));
    send_access(make_req(OP_WRITE, reg_addr(OFF_GOP6), 64'h1234_5678, WRITE_SIZE, 1'b1));

    // Attribute table: both edges of the low range, the middle entry and the top edge of the high range.
    send_access(make_req(OP_WRITE, mar_addr(8'd64), 64'h3, WRITE_SIZE, 1'b1));
    send_access(make_req(OP_READ, mar_addr(8'd64), '0, 4'd0, 1'b0));
    send_access(make_req(OP_READ, mar_addr(8'd63), '0, 4'd0, 1'b0));
    send_access(make_req(OP_WRITE, mar_addr(8'd103), 64'h1, WRITE_SIZE, 1'b1));
    send_access(make_req(OP_WRITE, mar_addr(8'd104), 64'h1, WRITE_SIZE, 1'b1));
    send_access(make_req(OP_READ, mar_addr(8'd128), '0, 4'd0, 1'b0));
    send_access(make_req(OP_READ, mar_addr(8'd223), '0, 4'd0, 1'b0));
    send_access(make_req(OP_READ, mar_addr(8'd224), '0, 4'd0, 1'b0));
    send_access(make_req(OP_READ, mar_addr(8'd255), '0, 4'd0, 1'b0));

    // Just outside the window on both sides, an unaligned write, a bad size,
    // data wider than 32 bits and the top of the address space.
    send_access(make_req(OP_READ, WIN_BASE - 32'd4, '0, 4'd0, 1'b0));
    send_access(make_req(OP_READ, WIN_BASE + 32'h1_0000, '0, 4'd0, 1'b0));
    send_access(make_req(OP_WRITE, WIN_BASE + 32'd1, 64'h1, WRITE_SIZE, 1'b1));
    send_access(make_req(OP_WRITE, reg_addr(OFF_L2_CFG), 64'h5, 4'd8, 1'b1));
    send_access(make_req(OP_WRITE, reg_addr(OFF_L2_CFG), 64'hffff_ffff_0000_0005,
                         WRITE_SIZE, 1'b1));
    send_access(make_req(OP_READ, 32'hffff_ffff, '0, 4'd0, 1'b0));

    // Random traffic with gaps on both sides.
    repeat (300) send_access(random_access());

    // Back-to-back requests while the response side holds off for a long
    // stretch, so the block fills up and stalls its request port.
    hold_long = 1'b1;
    tx_quiet  = 1'b1;
    repeat (40) send_access(random_access());

    // A stretch with no idling on either side.
    rx_quiet = 1'b1;
    repeat (100) send_access(random_access());
    tx_quiet = 1'b0;
    rx_quiet = 1'b0;

    // Pause until every response is back, then resume random traffic.
    drain_requests();
    repeat (210) send_access(random_access());

    drain_requests();
    repeat (4) @(posedge clk);
    if (sb.error_count == 0 && sb.outstanding() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
